FILE: design/csvfs_pkg.sv
package csvfs_pkg;

	localparam logic [7:0] NL_BYTE = 8'h0a;
	localparam logic [7:0] CR_BYTE = 8'h0d;

	localparam int MAX_RES = 4;
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	localparam logic [7:0] DELIM_RESET = 8'd44;
	localparam logic [7:0] QUOTE_RESET = 8'd34;
	localparam logic [7:0] ESCAPE_RESET = 8'd34;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_DELIM = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_QUOTE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 2'd2;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_AFTER
	} mode_t;

	typedef struct packed {
		logic [7:0] delim;
		logic [7:0] quote;
		logic [7:0] escape;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  cr;
		logic  esc;
	} state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       field_end;
		logic       record_end;
	} res_t;

endpackage

FILE: design/csvfs_parse.sv
module csvfs_parse (
	input  csvfs_pkg::cfg_t                         cfg,
	input  csvfs_pkg::state_t                       st,
	input  logic [7:0]                              data_byte,
	input  logic                                    is_last,
	output csvfs_pkg::state_t                       st_nx,
	output csvfs_pkg::res_t [csvfs_pkg::MAX_RES-1:0] res,
	output logic [csvfs_pkg::RES_CNT_W-1:0]         cnt
);

	// outcome of feeding one byte to the field machine: up to two results
	typedef struct packed {
		csvfs_pkg::mode_t mode;
		logic             esc;
		logic [1:0]       n;
		csvfs_pkg::res_t  r0;
		csvfs_pkg::res_t  r1;
	} tb_t;

	localparam int NCAND = 6;

	function automatic csvfs_pkg::res_t mk_byte(input logic [7:0] b);
		csvfs_pkg::res_t r;
		r = '0;
		r.out_byte = b;
		r.has_byte = 1'b1;
		return r;
	endfunction

	function automatic csvfs_pkg::res_t mk_end(input logic rec);
		csvfs_pkg::res_t r;
		r = '0;
		r.field_end = 1'b1;
		r.record_end = rec;
		return r;
	endfunction

	function automatic tb_t start_fn(input logic [7:0] c, input csvfs_pkg::cfg_t k,
			input logic esc);
		tb_t t;
		t = '0;
		t.esc = esc;
		if (c == k.quote) begin
			t.mode = csvfs_pkg::MODE_QUOTED;
			t.esc = 1'b0;
		end else if (c == k.delim) begin
			t.mode = csvfs_pkg::MODE_START;
			t.n = 2'd1;
			t.r0 = mk_end(1'b0);
		end else begin
			t.mode = csvfs_pkg::MODE_PLAIN;
			t.n = 2'd1;
			t.r0 = mk_byte(c);
		end
		return t;
	endfunction

	// closing quote already seen: the field ends, then the byte starts anew unless it is the delimiter
	function automatic tb_t after_fn(input logic [7:0] c, input csvfs_pkg::cfg_t k);
		tb_t t;
		tb_t s;
		s = start_fn(c, k, 1'b0);
		t = '0;
		t.r0 = mk_end(1'b0);
		if (c == k.delim) begin
			t.mode = csvfs_pkg::MODE_START;
			t.n = 2'd1;
		end else begin
			t.mode = s.mode;
			t.esc = s.esc;
			t.n = s.n + 2'd1;
			t.r1 = s.r0;
		end
		return t;
	endfunction

	function automatic tb_t quoted_fn(input logic [7:0] c, input csvfs_pkg::cfg_t k,
			input logic esc);
		tb_t t;
		t = '0;
		t.mode = csvfs_pkg::MODE_QUOTED;
		if (esc && c == k.quote) begin
			t.n = 2'd1;
			t.r0 = mk_byte(k.quote);
		end else if (esc && k.escape == k.quote) begin
			t = after_fn(c, k);
		end else begin
			// a lone escape that precedes a non-quote byte is literal
			if (esc) begin
				t.n = 2'd1;
				t.r0 = mk_byte(k.escape);
			end
			if (c == k.escape) begin
				t.esc = 1'b1;
			end else if (c == k.quote) begin
				t.mode = csvfs_pkg::MODE_AFTER;
			end else if (esc) begin
				t.n = 2'd2;
				t.r1 = mk_byte(c);
			end else begin
				t.n = 2'd1;
				t.r0 = mk_byte(c);
			end
		end
		return t;
	endfunction

	function automatic tb_t take_byte(input logic [7:0] c, input csvfs_pkg::cfg_t k,
			input csvfs_pkg::mode_t mode, input logic esc);
		tb_t t;
		t = '0;
		case (mode)
			csvfs_pkg::MODE_START: t = start_fn(c, k, esc);
			csvfs_pkg::MODE_PLAIN: begin
				t.esc = esc;
				t.n = 2'd1;
				if (c == k.delim) begin
					t.mode = csvfs_pkg::MODE_START;
					t.r0 = mk_end(1'b0);
				end else begin
					t.mode = csvfs_pkg::MODE_PLAIN;
					t.r0 = mk_byte(c);
				end
			end
			csvfs_pkg::MODE_QUOTED: t = quoted_fn(c, k, esc);
			csvfs_pkg::MODE_AFTER: t = after_fn(c, k);
			default: t = start_fn(c, k, esc);
		endcase
		return t;
	endfunction

	logic                          is_nl;
	logic                          is_cr;
	logic                          use_t1;
	logic                          use_t2;
	logic                          end_line;
	logic                          esc_flush;
	tb_t                           t1;
	tb_t                           t2;
	csvfs_pkg::mode_t              m1;
	logic                          e1;
	csvfs_pkg::mode_t              m2;
	logic                          e2;
	csvfs_pkg::res_t [NCAND-1:0]   cand;
	logic [NCAND-1:0]              cen;

	always_comb begin
		is_nl = (data_byte == csvfs_pkg::NL_BYTE);
		is_cr = (data_byte == csvfs_pkg::CR_BYTE);
		use_t1 = st.cr && !is_nl;
		use_t2 = !is_nl && !is_cr;

		// held carriage return turns out to be an ordinary byte
		t1 = take_byte(csvfs_pkg::CR_BYTE, cfg, st.mode, st.esc);
		m1 = use_t1 ? t1.mode : st.mode;
		e1 = use_t1 ? t1.esc : st.esc;
		t2 = take_byte(data_byte, cfg, m1, e1);
		m2 = use_t2 ? t2.mode : m1;
		e2 = use_t2 ? t2.esc : e1;

		end_line = is_nl || is_last;
		esc_flush = (m2 == csvfs_pkg::MODE_QUOTED) && e2 && (cfg.escape != cfg.quote);

		cand[0] = t1.r0;
		cand[1] = t1.r1;
		cand[2] = t2.r0;
		cand[3] = t2.r1;
		cand[4] = mk_byte(cfg.escape);
		cand[5] = mk_end(1'b1);
		cen[0] = use_t1 && (t1.n != 2'd0);
		cen[1] = use_t1 && (t1.n == 2'd2);
		cen[2] = use_t2 && (t2.n != 2'd0);
		cen[3] = use_t2 && (t2.n == 2'd2);
		cen[4] = end_line && esc_flush;
		cen[5] = end_line;

		// results beyond the fourth are dropped
		res = '0;
		cnt = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cen[i] && cnt < csvfs_pkg::RES_CNT_W'(csvfs_pkg::MAX_RES)) begin
				res[cnt[$clog2(csvfs_pkg::MAX_RES)-1:0]] = cand[i];
				cnt = cnt + csvfs_pkg::RES_CNT_W'(1);
			end
		end

		if (end_line) begin
			st_nx.mode = csvfs_pkg::MODE_START;
			st_nx.esc = 1'b0;
			st_nx.cr = 1'b0;
		end else begin
			st_nx.mode = m2;
			st_nx.esc = e2;
			st_nx.cr = is_cr;
		end
	end

endmodule

FILE: design/csv_field_splitter_unit.sv
// CSV field splitter: one text byte in per item, field content bytes and
// end marks out, one result per item on the output side.
// s_axis: tdata carries the byte, tlast flags the final byte of the stream
// (it closes an open last line). m_axis: tdata is a content byte (zero when
// there is none), tuser flags has_byte, field_end and record_end, and tlast
// marks the last result caused by one input byte. A byte may cause no result
// or up to four.
// cfg: cfg_index 0 delimiter, 1 quote, 2 escape; write only while idle.
// Path: an accepted byte is registered in the input register, then parsed
// combinationally into the result register once that register is free.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the receiver is ready; a byte with more results holds the
// input until the result register has drained them, one result per cycle
// while the receiver is ready.
// Reset clears the parser to field start and loads comma, double quote and
// double quote as delimiter, quote and escape. When the receiver stalls the
// result register holds and s_axis_tready falls once one byte waits in the
// input register.
module csv_field_splitter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata, // data_byte
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata, // out_byte
	output logic [2:0]                        m_axis_tuser, // has_byte, field_end, record_end
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csvfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                        cfg_data
);

	localparam int CW = csvfs_pkg::RES_CNT_W;

	csvfs_pkg::cfg_t                          cfg_q;
	csvfs_pkg::state_t                        st_q;
	csvfs_pkg::state_t                        st_nx;

	logic                                     valid_s1;
	logic [7:0]                               byte_s1;
	logic                                     last_s1;

	csvfs_pkg::res_t [csvfs_pkg::MAX_RES-1:0] res_nx;
	logic [CW-1:0]                            cnt_nx;
	csvfs_pkg::res_t [csvfs_pkg::MAX_RES-1:0] res_s2;
	logic [CW-1:0]                            left_s2;

	logic                                     s2_free;
	logic                                     adv;
	logic                                     out_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim <= csvfs_pkg::DELIM_RESET;
			cfg_q.quote <= csvfs_pkg::QUOTE_RESET;
			cfg_q.escape <= csvfs_pkg::ESCAPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				csvfs_pkg::REG_DELIM: cfg_q.delim <= cfg_data;
				csvfs_pkg::REG_QUOTE: cfg_q.quote <= cfg_data;
				csvfs_pkg::REG_ESCAPE: cfg_q.escape <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_take = m_axis_tvalid && m_axis_tready;
	// result register can load when empty or when its final result leaves now
	assign s2_free = (left_s2 == '0) || (left_s2 == CW'(1) && m_axis_tready);
	assign adv = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	csvfs_parse u_parse (
		.cfg       (cfg_q),
		.st        (st_q),
		.data_byte (byte_s1),
		.is_last   (last_s1),
		.st_nx     (st_nx),
		.res       (res_nx),
		.cnt       (cnt_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= csvfs_pkg::MODE_START;
			st_q.cr <= 1'b0;
			st_q.esc <= 1'b0;
			left_s2 <= '0;
		end else if (adv) begin
			st_q <= st_nx;
			left_s2 <= cnt_nx;
		end else if (out_take) begin
			left_s2 <= left_s2 - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nx;
		end else if (out_take) begin
			res_s2 <= {csvfs_pkg::res_t'('0), res_s2[csvfs_pkg::MAX_RES-1:1]};
		end
	end

	assign m_axis_tvalid = (left_s2 != '0);
	assign m_axis_tdata = res_s2[0].out_byte;
	assign m_axis_tuser = {res_s2[0].record_end, res_s2[0].field_end, res_s2[0].has_byte};
	assign m_axis_tlast = (left_s2 == CW'(1));

	a_rec_has_field_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
		else $error("record end without field end");

	a_byte_not_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("content byte carries an end mark");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while result register empty");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_s2 <= CW'(csvfs_pkg::MAX_RES))
		else $error("result count out of range");

endmodule

FILE: tb/tb_top.sv
module tb_top;
	import csvfs_pkg::*;

	localparam int LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} text_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       field_end;
		logic       record_end;
		logic       run_last;
	} token_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'h00;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [7:0]             m_axis_tdata;
	logic [2:0]             m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_DELIM;
	logic [7:0]             cfg_data = 8'h00;

	csv_field_splitter_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	text_t  text_q[$];
	token_t pending_tokens[$];
	text_t  next_text;
	token_t want;

	int   n_pushed = 0;
	int   n_taken = 0;
	int   n_pred = 0;
	int   n_got = 0;
	int   n_cfg = 0;
	int   errors = 0;
	int   cycles = 0;
	int   idle_pct = 28;
	int   hold_reqs = 0;
	int   holds_done = 0;
	int   hold_left = 0;
	logic in_fire = 1'b0;

	// parser copy
	mode_t p_mode = MODE_START;
	logic  p_cr = 1'b0;
	logic  p_esc = 1'b0;
	logic  p_open = 1'b0;
	cfg_t  p_cfg = '{DELIM_RESET, QUOTE_RESET, ESCAPE_RESET};
	int    step_cnt;

	task put_token(input logic [7:0] b, input logic has, input logic fe, input logic re);
		token_t t;
		if (step_cnt < MAX_RES) begin
			t.out_byte = has ? b : 8'h00;
			t.has_byte = has;
			t.field_end = fe;
			t.record_end = re;
			t.run_last = 1'b0;
			pending_tokens.insert(pending_tokens.size(), t);
			step_cnt++;
		end
	endtask

	task scan_byte(input logic [7:0] c);
		logic again;
		logic scan;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (p_mode)
			MODE_START: begin
				if (c == p_cfg.quote) begin
					p_mode = MODE_QUOTED;
					p_esc = 1'b0;
				end else if (c == p_cfg.delim) begin
					put_token(8'h00, 1'b0, 1'b1, 1'b0);
				end else begin
					put_token(c, 1'b1, 1'b0, 1'b0);
					p_mode = MODE_PLAIN;
				end
			end
			MODE_PLAIN: begin
				if (c == p_cfg.delim) begin
					put_token(8'h00, 1'b0, 1'b1, 1'b0);
					p_mode = MODE_START;
				end else begin
					put_token(c, 1'b1, 1'b0, 1'b0);
				end
			end
			MODE_QUOTED: begin
				scan = 1'b1;
				if (p_esc) begin
					p_esc = 1'b0;
					scan = 1'b0;
					if (c == p_cfg.quote) begin
						put_token(p_cfg.quote, 1'b1, 1'b0, 1'b0);
					end else if (p_cfg.escape == p_cfg.quote) begin
						// the pending escape was really the closing quote
						p_mode = MODE_AFTER;
						again = 1'b1;
					end else begin
						put_token(p_cfg.escape, 1'b1, 1'b0, 1'b0);
						scan = 1'b1;
					end
				end
				if (scan) begin
					if (c == p_cfg.escape)
						p_esc = 1'b1;
					else if (c == p_cfg.quote)
						p_mode = MODE_AFTER;
					else
						put_token(c, 1'b1, 1'b0, 1'b0);
				end
			end
			default: begin
				put_token(8'h00, 1'b0, 1'b1, 1'b0);
				p_mode = MODE_START;
				again = (c != p_cfg.delim);
			end
			endcase
		end
	endtask

	task close_record();
		if (p_mode == MODE_QUOTED && p_esc && p_cfg.escape != p_cfg.quote)
			put_token(p_cfg.escape, 1'b1, 1'b0, 1'b0);
		put_token(8'h00, 1'b0, 1'b1, 1'b1);
		p_mode = MODE_START;
		p_esc = 1'b0;
		p_cr = 1'b0;
		p_open = 1'b0;
	endtask

	task predict_byte(input logic [7:0] c, input logic fin);
		token_t t;
		step_cnt = 0;
		if (c == NL_BYTE) begin
			p_cr = 1'b0;
			close_record();
		end else begin
			if (p_cr) begin
				p_cr = 1'b0;
				scan_byte(CR_BYTE);
			end
			if (c == CR_BYTE)
				p_cr = 1'b1;
			else
				scan_byte(c);
			p_open = 1'b1;
		end
		if (fin && p_open) begin
			p_cr = 1'b0;
			close_record();
		end
		if (step_cnt > 0) begin
			t = pending_tokens[pending_tokens.size() - 1];
			t.run_last = 1'b1;
			pending_tokens[pending_tokens.size() - 1] = t;
		end
		n_pred += step_cnt;
	endtask

	task check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sampling side: predictions, register writes and result checks
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_tokens.size() == 0) begin
					$error("result item with no expected token: data %0h user %0h last %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = pending_tokens.pop_front();
					check_field("out_byte", want.out_byte, m_axis_tdata);
					check_field("has_byte", 8'(want.has_byte), 8'(m_axis_tuser[0]));
					check_field("field_end", 8'(want.field_end), 8'(m_axis_tuser[1]));
					check_field("record_end", 8'(want.record_end), 8'(m_axis_tuser[2]));
					check_field("run_last", 8'(want.run_last), 8'(m_axis_tlast));
					n_got++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_DELIM:  p_cfg.delim = cfg_data;
				REG_QUOTE:  p_cfg.quote = cfg_data;
				REG_ESCAPE: p_cfg.escape = cfg_data;
				default: ;
				endcase
				n_cfg++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_byte(s_axis_tdata, s_axis_tlast);
				n_taken++;
			end
		end
	end

	// byte sender
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (text_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_text = text_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_text.data;
				s_axis_tlast <= next_text.is_last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_reqs != holds_done) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task push_byte(input logic [7:0] b, input logic fin);
		text_t t;
		t.data = b;
		t.is_last = fin;
		text_q.insert(text_q.size(), t);
		n_pushed++;
	endtask

	task push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	// no result may be owed and the parser may still be busy on a silent item
	task drain();
		wait (n_taken == n_pushed && n_got == n_pred);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		int seen;
		seen = n_cfg;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		wait (n_cfg != seen);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function logic [7:0] pick_reg_byte();
		if ($urandom_range(1) == 0)
			return 8'($urandom_range(255));
		case ($urandom_range(5))
		0: return 8'h2c;
		1: return 8'h22;
		2: return 8'h5c;
		3: return 8'h09;
		4: return NL_BYTE;
		default: return CR_BYTE;
		endcase
	endfunction

	// byte mix leaning on the current special characters
	function logic [7:0] pick_text_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12)
			return p_cfg.delim;
		else if (r < 26)
			return p_cfg.quote;
		else if (r < 34)
			return p_cfg.escape;
		else if (r < 42)
			return NL_BYTE;
		else if (r < 48)
			return CR_BYTE;
		else if (r < 88)
			return 8'(8'h61 + $urandom_range(25));
		return 8'($urandom_range(255));
	endfunction

	task push_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			push_byte(pick_text_byte(), $urandom_range(99) < 3);
	endtask

	int         ph;
	logic [7:0] d_v, q_v, e_v;

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default comma and double quote
		push_text("\n");
		push_text("\"i\"\"j\"k,\"m\"\r\n");
		push_text("\"c\rg\n");
		push_byte(8'h65, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(CR_BYTE, 1'b1);
		push_byte(NL_BYTE, 1'b1);

		// escape distinct from quote
		drain();
		write_reg(REG_QUOTE, 8'h27);
		write_reg(REG_ESCAPE, 8'h5c);
		push_text("'a\\'\\c\\\n");
		push_text("'x''\n");

		for (ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
			0: begin
				d_v = 8'h00;
				q_v = 8'hff;
				e_v = 8'hff;
			end
			1: begin
				d_v = 8'hff;
				q_v = 8'h00;
				e_v = 8'h00;
			end
			default: begin
				d_v = pick_reg_byte();
				q_v = pick_reg_byte();
				e_v = pick_reg_byte();
			end
			endcase
			write_reg(REG_DELIM, d_v);
			write_reg(REG_QUOTE, q_v);
			write_reg(REG_ESCAPE, e_v);
			idle_pct = (ph == 2) ? 0 : 28;
			if (ph == 1) begin
				push_random(62);
				hold_reqs++;
			end else if (ph == 3) begin
				push_random(30);
				drain();
				push_random(32);
			end else begin
				push_random(62);
			end
		end

		drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
design/csvfs_pkg.sv
design/csvfs_parse.sv
design/csv_field_splitter_unit.sv
tb/tb_top.sv
